FILE: sv/sopa_pkg.sv
package sopa_pkg;

   localparam int ADDR_FIELD_WIDTH = 32;
   localparam int SIZE_WIDTH       = 17;
   localparam int COUNT_WIDTH      = 9;
   localparam int STATUS_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 32;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_ADDR = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OBJECT_SIZE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POOL_BASE    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OBJECT_COUNT = 2'd2;

   localparam logic [SIZE_WIDTH-1:0]       RESET_OBJECT_SIZE  = 17'd32;
   localparam logic [ADDR_FIELD_WIDTH-1:0] RESET_POOL_BASE    = 32'd0;
   localparam logic [COUNT_WIDTH-1:0]      RESET_OBJECT_COUNT = 9'd256;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FAIL
   } state_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctrl_type;

   typedef struct packed {
      logic busy;
      logic rem_zero;
   } unit_stat_type;

endpackage

FILE: sv/sopa_req_if.sv
interface sopa_req_if;
   import sopa_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [ADDR_FIELD_WIDTH-1:0] address;

   modport source (output valid, output mode, output address, input ready);
   modport sink (input valid, input mode, input address, output ready);

endinterface

FILE: sv/sopa_rsp_if.sv
interface sopa_rsp_if;
   import sopa_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [ADDR_FIELD_WIDTH-1:0] object_address;
   logic [STATUS_WIDTH-1:0]     status;
   logic [COUNT_WIDTH-1:0]      free_objects;

   modport source (
      output valid, output object_address, output status, output free_objects,
      input ready
   );
   modport sink (
      input valid, input object_address, input status, input free_objects,
      output ready
   );

endinterface

FILE: sv/sopa_ram.sv
module sopa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sopa_arith_unit.sv
module sopa_arith_unit #(
   parameter int ADDR_WIDTH = 32,
   parameter int LINK_WIDTH = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sopa_pkg::unit_ctrl_type       ctrl,
   input  logic [ADDR_WIDTH-1:0]         opa,
   input  logic [LINK_WIDTH-1:0]         opm,
   input  logic [sopa_pkg::SIZE_WIDTH-1:0] divisor,
   output sopa_pkg::unit_stat_type       stat,
   output logic [ADDR_WIDTH-1:0]         result
);
   import sopa_pkg::*;

   localparam int REM_WIDTH  = SIZE_WIDTH + 1;
   localparam int SUM_WIDTH  = (ADDR_WIDTH > REM_WIDTH) ? ADDR_WIDTH : REM_WIDTH;
   localparam int STEPS_MAX  = (ADDR_WIDTH > LINK_WIDTH) ? ADDR_WIDTH : LINK_WIDTH;
   localparam int STEP_WIDTH = $clog2(STEPS_MAX + 1);

   logic [ADDR_WIDTH-1:0] acc_ff, acc_in;
   logic [ADDR_WIDTH-1:0] mcand_ff, mcand_in;
   logic [LINK_WIDTH-1:0] mplier_ff, mplier_in;
   logic [SIZE_WIDTH-1:0] rem_ff, rem_in;
   unit_op_type           op_ff, op_in;
   logic                  busy_ff, busy_in;
   logic [STEP_WIDTH-1:0] steps_ff, steps_in;

   logic [REM_WIDTH-1:0]  trial;
   logic [SUM_WIDTH-1:0]  add_a, add_b;
   logic                  sub_en;
   logic [SUM_WIDTH:0]    sum;
   logic                  fits;

   // shared adder: shift-add multiply or restoring divide, one bit a cycle
   always_comb begin
      trial = {rem_ff, acc_ff[ADDR_WIDTH-1]};
      if (op_ff == OP_DIV) begin
         add_a  = SUM_WIDTH'(trial);
         add_b  = SUM_WIDTH'(divisor);
         sub_en = 1'b1;
      end else begin
         add_a  = SUM_WIDTH'(acc_ff);
         add_b  = mplier_ff[0] ? SUM_WIDTH'(mcand_ff) : '0;
         sub_en = 1'b0;
      end
      sum  = {1'b0, add_a} + {1'b0, (sub_en ? ~add_b : add_b)} + (SUM_WIDTH + 1)'(sub_en);
      // carry out on subtract: trial remainder not below divisor
      fits = sum[SUM_WIDTH];
   end

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      op_in     = op_ff;
      busy_in   = busy_ff;
      steps_in  = steps_ff;
      if (ctrl.start) begin
         acc_in    = opa;
         mcand_in  = ADDR_WIDTH'(divisor);
         mplier_in = opm;
         rem_in    = '0;
         op_in     = ctrl.op;
         busy_in   = 1'b1;
         steps_in  = (ctrl.op == OP_DIV) ? STEP_WIDTH'(ADDR_WIDTH) : STEP_WIDTH'(LINK_WIDTH);
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            acc_in = {acc_ff[ADDR_WIDTH-2:0], fits};
            rem_in = fits ? sum[SIZE_WIDTH-1:0] : trial[SIZE_WIDTH-1:0];
         end else begin
            acc_in    = sum[ADDR_WIDTH-1:0];
            mcand_in  = {mcand_ff[ADDR_WIDTH-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
         end
         steps_in = steps_ff - 1'b1;
         if (steps_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      op_ff     <= op_in;
      steps_ff  <= steps_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.rem_zero = (rem_ff == '0);
   assign result        = acc_ff;

endmodule

FILE: sv/slab_object_pool_allocator.sv
// Allocate: the shift-add unit forms base + head * size; the response is registered
// once the unit is done and the response register is free, and only then is the next request taken.
// Free: the offset from the pool base is divided by the object size, one quotient bit a cycle
// through the same shared adder. Empty pool, zero size: the request fails without the unit.
// Reset (synchronous) and every object_count write start a link sweep over all
// MAX_OBJECTS link entries (256 by default); no item is taken until it ends.
module slab_object_pool_allocator #(
   parameter int MAX_OBJECTS = 256,
   parameter int ADDR_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   sopa_req_if.sink                            req_chan,
   sopa_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [sopa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sopa_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import sopa_pkg::*;

   localparam int LINK_WIDTH  = $clog2(MAX_OBJECTS + 1);
   localparam int INDEX_WIDTH = $clog2(MAX_OBJECTS);
   localparam int CMP_WIDTH   = (LINK_WIDTH > COUNT_WIDTH) ? LINK_WIDTH : COUNT_WIDTH;
   localparam int QUO_WIDTH   = (ADDR_WIDTH > LINK_WIDTH) ? ADDR_WIDTH : LINK_WIDTH;
   localparam logic [CMP_WIDTH-1:0]  MAX_WIDE   = CMP_WIDTH'(MAX_OBJECTS);
   localparam logic [LINK_WIDTH-1:0] LAST_INDEX = LINK_WIDTH'(MAX_OBJECTS - 1);

   function automatic logic [LINK_WIDTH-1:0] clamp_count(input logic [COUNT_WIDTH-1:0] c);
      logic [CMP_WIDTH-1:0] w;
      w = CMP_WIDTH'(c);
      return (w > MAX_WIDE) ? LINK_WIDTH'(MAX_WIDE) : LINK_WIDTH'(w);
   endfunction

   state_type                   state_ff, state_in;
   logic [SIZE_WIDTH-1:0]       size_ff, size_in;
   logic [ADDR_FIELD_WIDTH-1:0] base_ff, base_in;
   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic [LINK_WIDTH-1:0]       head_ff, head_in;
   logic [LINK_WIDTH-1:0]       total_ff, total_in;
   logic [LINK_WIDTH-1:0]       clear_ff, clear_in;
   logic [STATUS_WIDTH-1:0]     fail_status_ff, fail_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ADDR_FIELD_WIDTH-1:0] rsp_addr_ff, rsp_addr_in;
   logic [STATUS_WIDTH-1:0]     rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]      rsp_free_ff, rsp_free_in;

   logic [LINK_WIDTH-1:0]  eff_count;
   logic                   count_wr;
   logic                   out_free;
   logic                   alloc_ok;
   logic                   free_ok;
   logic                   size_zero;
   logic                   commit;
   logic                   req_ready;
   logic [ADDR_WIDTH-1:0]  offset;
   logic [ADDR_WIDTH-1:0]  unit_opa;
   logic [ADDR_WIDTH-1:0]  unit_result;
   unit_ctrl_type          unit_ctrl;
   unit_stat_type          unit_stat;

   logic                   link_we;
   logic [INDEX_WIDTH-1:0] link_waddr;
   logic [LINK_WIDTH-1:0]  link_wdata;
   logic [LINK_WIDTH-1:0]  link_rdata;

   assign eff_count = clamp_count(count_ff);
   assign count_wr  = csr_we && (csr_index == CSR_OBJECT_COUNT);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign alloc_ok  = (total_ff != '0) && (head_ff < eff_count);
   assign size_zero = (size_ff == '0);
   assign offset    = ADDR_WIDTH'(req_chan.address) - ADDR_WIDTH'(base_ff);
   assign unit_opa  = (req_chan.mode == MODE_FREE) ? offset : ADDR_WIDTH'(base_ff);
   assign free_ok   = unit_stat.rem_zero && (QUO_WIDTH'(unit_result) < QUO_WIDTH'(eff_count));

   sopa_ram #(
      .WIDTH (LINK_WIDTH),
      .DEPTH (MAX_OBJECTS)
   ) u_link (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (head_ff[INDEX_WIDTH-1:0]),
      .rd_data (link_rdata)
   );

   sopa_arith_unit #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .LINK_WIDTH (LINK_WIDTH)
   ) u_unit (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (unit_ctrl),
      .opa     (unit_opa),
      .opm     (head_ff),
      .divisor (size_ff),
      .stat    (unit_stat),
      .result  (unit_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_ff == LAST_INDEX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.mode == MODE_ALLOC) begin
                  state_in = alloc_ok ? ST_MUL : ST_FAIL;
               end else begin
                  state_in = size_zero ? ST_FAIL : ST_DIV;
               end
            end
         end
         ST_MUL, ST_DIV: begin
            if (!unit_stat.busy && out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FAIL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (count_wr) begin
         state_in = ST_CLEAR;
      end
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      unit_ctrl  = '{start: 1'b0, op: OP_MUL};
      commit     = 1'b0;
      link_we    = 1'b0;
      link_waddr = clear_ff[INDEX_WIDTH-1:0];
      link_wdata = clear_ff + 1'b1;
      unique case (state_ff)
         ST_CLEAR: link_we = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.mode == MODE_ALLOC) begin
                  unit_ctrl = '{start: alloc_ok, op: OP_MUL};
               end else begin
                  unit_ctrl = '{start: !size_zero, op: OP_DIV};
               end
            end
         end
         ST_MUL: commit = !unit_stat.busy && out_free;
         ST_DIV: begin
            if (!unit_stat.busy && out_free) begin
               commit = 1'b1;
               if (free_ok) begin
                  // push: the freed slot points at the old head
                  link_we    = 1'b1;
                  link_waddr = unit_result[INDEX_WIDTH-1:0];
                  link_wdata = head_ff;
               end
            end
         end
         ST_FAIL: commit = out_free;
         default: ;
      endcase
   end

   // register next values
   always_comb begin
      size_in        = size_ff;
      base_in        = base_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      total_in       = total_ff;
      clear_in       = clear_ff;
      fail_status_in = fail_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in    = rsp_addr_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_free_in    = rsp_free_ff;

      if (state_ff == ST_CLEAR) begin
         clear_in = clear_ff + 1'b1;
      end
      if (state_ff == ST_IDLE && req_chan.valid) begin
         fail_status_in = (req_chan.mode == MODE_ALLOC) ? STATUS_EMPTY : STATUS_BAD_ADDR;
      end

      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = '0;
         rsp_status_in = STATUS_OK;
         unique case (state_ff)
            ST_MUL: begin
               head_in     = link_rdata;
               total_in    = total_ff - 1'b1;
               rsp_addr_in = ADDR_FIELD_WIDTH'(unit_result);
            end
            ST_DIV: begin
               if (free_ok) begin
                  head_in = LINK_WIDTH'(unit_result);
                  // double free: hold the count at its ceiling
                  if (total_ff < eff_count) begin
                     total_in = total_ff + 1'b1;
                  end
               end else begin
                  rsp_status_in = STATUS_BAD_ADDR;
               end
            end
            default: rsp_status_in = fail_status_ff;
         endcase
         rsp_free_in = COUNT_WIDTH'(total_in);
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_OBJECT_SIZE: size_in = csr_wdata[SIZE_WIDTH-1:0];
            CSR_POOL_BASE:   base_in = csr_wdata[ADDR_FIELD_WIDTH-1:0];
            CSR_OBJECT_COUNT: begin
               count_in = csr_wdata[COUNT_WIDTH-1:0];
               head_in  = '0;
               total_in = clamp_count(csr_wdata[COUNT_WIDTH-1:0]);
               clear_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         size_ff      <= RESET_OBJECT_SIZE;
         base_ff      <= RESET_POOL_BASE;
         count_ff     <= RESET_OBJECT_COUNT;
         head_ff      <= '0;
         total_ff     <= clamp_count(RESET_OBJECT_COUNT);
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fail_status_ff <= fail_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_free_ff    <= rsp_free_in;
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.object_address = rsp_addr_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.free_objects   = rsp_free_ff;

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      total_ff <= eff_count)
      else $error("free count above object count");

   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(state_ff == ST_MUL || state_ff == ST_DIV || state_ff == ST_FAIL))
      else $error("response raised outside a commit");

   a_alloc_pops_one: assert property (@(posedge clock) disable iff (reset)
      (commit && state_ff == ST_MUL && !count_wr) |=> total_ff == $past(total_ff) - 1'b1)
      else $error("allocate did not take exactly one object");

endmodule
